FILE: hw/rtl/bba_pkg.sv
// Package with the shared constants, codes and types of the buddy block allocator.
`timescale 1ns / 1ps
package bba_pkg;

  localparam int unsigned NumTopBlocksDef = 32;
  localparam int unsigned TopOrderDef     = 10;
  localparam int unsigned UnitBytesDef    = 128;
  localparam int unsigned HeaderReset     = 40;

  localparam int unsigned ReqBytesW = 27;
  localparam int unsigned BlkAddrW  = 15;
  localparam int unsigned HeaderW   = 7;
  localparam int unsigned OrderOutW = 4;
  localparam int unsigned CountW    = 16;
  localparam int unsigned TotalW    = ReqBytesW + 1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FREE  = 2'd1,
    ST_BAD_SIZE = 2'd2,
    ST_BAD_ADDR = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SIZE,
    S_A_RD,
    S_A_CHK,
    S_SPLIT,
    S_F_RD,
    S_F_CHK,
    S_M_RD,
    S_M_CHK,
    S_M_ZERO,
    S_M_HEAD,
    S_RESP
  } bba_state_e;

endpackage

FILE: hw/rtl/bba_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module bba_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: hw/rtl/buddy_block_allocator.sv
// Top level of the buddy block allocator: sequencer, unit table and result register.
`timescale 1ns / 1ps
// An allocate probes each order from the wanted one up, in steps of the block size, and splits
// the block it finds down to the wanted order. A free that changes nothing leaves the table
// alone; else it marks the block free and merges it with free buddies of its order, up to the
// top order. One request is in flight at a time; the next is accepted in the cycle after the
// result is loaded, and the result waits while the previous one is still held. After reset
// the unit table is cleared (32768 entries by default); config writes are taken at any time.
module buddy_block_allocator
  import bba_pkg::*;
#(
  parameter int unsigned NUM_TOP_BLOCKS = NumTopBlocksDef,
  parameter int unsigned TOP_ORDER      = TopOrderDef,
  parameter int unsigned UNIT_BYTES     = UnitBytesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bba_pkg::HeaderW-1:0]   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          req_type_i,
  input  logic [bba_pkg::ReqBytesW-1:0] request_bytes_i,
  input  logic [bba_pkg::BlkAddrW-1:0]  block_address_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    status_o,
  output logic [bba_pkg::BlkAddrW-1:0]  granted_address_o,
  output logic [bba_pkg::OrderOutW-1:0] granted_order_o,
  output logic [bba_pkg::CountW-1:0]    free_block_count_o
);

  localparam longint unsigned PoolUnits = longint'(NUM_TOP_BLOCKS) << TOP_ORDER;
  localparam longint unsigned TopBytes  = longint'(UNIT_BYTES) << TOP_ORDER;
  localparam int unsigned     AW        = $clog2(PoolUnits);
  localparam int unsigned     OW        = $clog2(TOP_ORDER + 1);
  localparam int unsigned     EW        = OW + 2;

  bba_state_e state_q, state_d;

  logic [HeaderW-1:0]  hdr_q;
  logic                type_q, type_d;
  logic [ReqBytesW-1:0] bytes_q, bytes_d;
  logic [BlkAddrW-1:0] blk_q, blk_d;
  logic [TotalW-1:0]   total_q, total_d;
  logic [OW-1:0]       want_q, want_d, n_q, n_d, k_q, k_d, ord_q, ord_d;
  logic [AW-1:0]       a_q, a_d, buddy_q, buddy_d, clr_q, clr_d;
  logic [CountW-1:0]   fcnt_q, fcnt_d;
  logic [1:0]          res_st_q, res_st_d;
  logic [AW-1:0]       res_addr_q, res_addr_d;
  logic [OW-1:0]       res_ord_q, res_ord_d;
  logic                out_valid_q, out_valid_d;
  logic [1:0]          out_st_q, out_st_d;
  logic [BlkAddrW-1:0] out_addr_q, out_addr_d;
  logic [OrderOutW-1:0] out_ord_q, out_ord_d;
  logic [CountW-1:0]   out_cnt_q, out_cnt_d;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;

  logic          e_head, e_free;
  logic [OW-1:0] e_ord;
  logic [AW:0]   a_next;
  logic [OW-1:0] want_calc;
  logic          size_bad;

  bba_ram #(
    .Width(EW),
    .Depth(int'(PoolUnits))
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign e_head = ram_rdata[EW-1];
  assign e_free = ram_rdata[EW-2];
  assign e_ord  = ram_rdata[OW-1:0];
  assign a_next = {1'b0, a_q} + ((AW + 1)'(1) << n_q);

  always_comb begin
    want_calc = OW'(TOP_ORDER);
    for (int k = TOP_ORDER; k >= 0; k--) begin
      if (64'(total_q) <= (64'(UNIT_BYTES) << k)) begin
        want_calc = OW'(k);
      end
    end
    size_bad = (bytes_q == '0) || (64'(total_q) > TopBytes);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (64'(clr_q) == PoolUnits - 1) state_d = S_IDLE;
      S_IDLE:  if (in_valid_i) state_d = req_type_i ? S_F_RD : S_SIZE;
      S_SIZE:  state_d = size_bad ? S_RESP : S_A_RD;
      S_A_RD:  state_d = S_A_CHK;
      S_A_CHK: begin
        if (e_head && e_free && e_ord == n_q) begin
          state_d = S_SPLIT;
        end else if (64'(a_next) >= PoolUnits && n_q == OW'(TOP_ORDER)) begin
          state_d = S_RESP;
        end else begin
          state_d = S_A_RD;
        end
      end
      S_SPLIT: if (k_q <= want_q) state_d = S_RESP;
      S_F_RD:  state_d = (64'(blk_q) >= PoolUnits) ? S_RESP : S_F_CHK;
      S_F_CHK: state_d = (!e_head || e_free) ? S_RESP : S_M_RD;
      S_M_RD:  state_d = (ord_q == OW'(TOP_ORDER)) ? S_RESP : S_M_CHK;
      S_M_CHK: state_d = (e_head && e_free && e_ord == ord_q) ? S_M_ZERO : S_RESP;
      S_M_ZERO: state_d = S_M_HEAD;
      S_M_HEAD: state_d = S_M_RD;
      S_RESP:  if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      default: state_d = S_CLEAR;
    endcase
  end

  always_comb begin
    type_d      = type_q;
    bytes_d     = bytes_q;
    blk_d       = blk_q;
    total_d     = total_q;
    want_d      = want_q;
    n_d         = n_q;
    k_d         = k_q;
    ord_d       = ord_q;
    a_d         = a_q;
    buddy_d     = buddy_q;
    clr_d       = clr_q;
    fcnt_d      = fcnt_q;
    res_st_d    = res_st_q;
    res_addr_d  = res_addr_q;
    res_ord_d   = res_ord_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_st_d    = out_st_q;
    out_addr_d  = out_addr_q;
    out_ord_d   = out_ord_q;
    out_cnt_d   = out_cnt_q;
    ram_we      = 1'b0;
    ram_waddr   = a_q;
    ram_wdata   = '0;
    ram_raddr   = a_q;
    in_ready_o  = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        if ((clr_q & AW'((64'(1) << TOP_ORDER) - 1)) == '0) begin
          ram_wdata = {2'b11, OW'(TOP_ORDER)};
        end
        clr_d = clr_q + 1'b1;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          type_d  = req_type_i;
          bytes_d = request_bytes_i;
          blk_d   = block_address_i;
          total_d = TotalW'(request_bytes_i) + TotalW'(hdr_q);
        end
      end
      S_SIZE: begin
        if (size_bad) begin
          res_st_d   = ST_BAD_SIZE;
          res_addr_d = '0;
          res_ord_d  = '0;
        end else begin
          want_d = want_calc;
          n_d    = want_calc;
          a_d    = '0;
        end
      end
      S_A_RD: ram_raddr = a_q;
      S_A_CHK: begin
        if (e_head && e_free && e_ord == n_q) begin
          k_d = n_q;
        end else if (64'(a_next) >= PoolUnits) begin
          a_d = '0;
          if (n_q == OW'(TOP_ORDER)) begin
            res_st_d   = ST_NO_FREE;
            res_addr_d = '0;
            res_ord_d  = '0;
          end else begin
            n_d = n_q + 1'b1;
          end
        end else begin
          a_d = a_next[AW-1:0];
        end
      end
      S_SPLIT: begin
        ram_we = 1'b1;
        if (k_q > want_q) begin
          ram_waddr = a_q + (AW'(1) << (k_q - 1'b1));
          ram_wdata = {2'b11, k_q - 1'b1};
          k_d       = k_q - 1'b1;
          fcnt_d    = fcnt_q + 1'b1;
        end else begin
          ram_waddr  = a_q;
          ram_wdata  = {2'b10, want_q};
          fcnt_d     = fcnt_q - 1'b1;
          res_st_d   = ST_OK;
          res_addr_d = a_q;
          res_ord_d  = want_q;
        end
      end
      S_F_RD: begin
        ram_raddr = AW'(blk_q);
        a_d       = AW'(blk_q);
        if (64'(blk_q) >= PoolUnits) begin
          res_st_d   = ST_BAD_ADDR;
          res_addr_d = '0;
          res_ord_d  = '0;
        end
      end
      S_F_CHK: begin
        if (!e_head) begin
          res_st_d   = ST_BAD_ADDR;
          res_addr_d = '0;
          res_ord_d  = '0;
        end else if (e_free) begin
          res_st_d   = ST_OK;
          res_addr_d = a_q;
          res_ord_d  = e_ord;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = a_q;
          ram_wdata = {2'b11, e_ord};
          fcnt_d    = fcnt_q + 1'b1;
          ord_d     = e_ord;
        end
      end
      S_M_RD: begin
        ram_raddr = a_q ^ (AW'(1) << ord_q);
        buddy_d   = a_q ^ (AW'(1) << ord_q);
        res_st_d   = ST_OK;
        res_addr_d = a_q;
        res_ord_d  = ord_q;
      end
      S_M_CHK: ;
      S_M_ZERO: begin
        ram_we    = 1'b1;
        ram_waddr = (buddy_q < a_q) ? a_q : buddy_q;
        ram_wdata = '0;
        if (buddy_q < a_q) a_d = buddy_q;
      end
      S_M_HEAD: begin
        ram_we    = 1'b1;
        ram_waddr = a_q;
        ram_wdata = {2'b11, ord_q + 1'b1};
        ord_d     = ord_q + 1'b1;
        fcnt_d    = fcnt_q - 1'b1;
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_st_d    = res_st_q;
          out_addr_d  = BlkAddrW'(res_addr_q);
          out_ord_d   = OrderOutW'(res_ord_q);
          out_cnt_d   = fcnt_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      fcnt_q      <= CountW'(NUM_TOP_BLOCKS);
      hdr_q       <= HeaderW'(HeaderReset);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      fcnt_q      <= fcnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) hdr_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    type_q     <= type_d;
    bytes_q    <= bytes_d;
    blk_q      <= blk_d;
    total_q    <= total_d;
    want_q     <= want_d;
    n_q        <= n_d;
    k_q        <= k_d;
    ord_q      <= ord_d;
    a_q        <= a_d;
    buddy_q    <= buddy_d;
    res_st_q   <= res_st_d;
    res_addr_q <= res_addr_d;
    res_ord_q  <= res_ord_d;
    out_st_q   <= out_st_d;
    out_addr_q <= out_addr_d;
    out_ord_q  <= out_ord_d;
    out_cnt_q  <= out_cnt_d;
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = out_st_q;
  assign granted_address_o  = out_addr_q;
  assign granted_order_o    = out_ord_q;
  assign free_block_count_o = out_cnt_q;

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> granted_address_o == '0 && granted_order_o == '0)
    else $error("failed transaction carries a nonzero block");

  a_split_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SPLIT |-> k_q >= want_q && type_q == 1'b0)
    else $error("split went below the wanted order");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_CLEAR |-> 64'(fcnt_q) <= PoolUnits)
    else $error("free block count exceeds the pool");

endmodule
